>>> rtl/vptp_pkg.sv
// Package: item types, pipeline state types and register indexes for the vertex pull block
`timescale 1ns / 1ps
package vptp_pkg;

  localparam int COORD_BITS    = 24;
  localparam int INDEX_BITS    = 10;
  localparam int PROG_BITS     = 17;
  localparam int PULL_BITS     = 23;
  localparam int PROD_BITS     = PULL_BITS + PROG_BITS;      // pull * progress
  localparam int ROOT_BITS     = 25;                         // sqrt of a 49-bit sum
  localparam int RAD_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS      = ROOT_BITS + 3;
  localparam int DEN_BITS      = ROOT_BITS + 16;             // d << 16
  localparam int QUOT_BITS     = COORD_BITS;
  localparam int NUM_BITS      = COORD_BITS + PROD_BITS;     // delta * pull * progress
  localparam int SPLIT_BITS    = PROD_BITS / 2;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X      = 2'd0,
    REG_CENTER_Y      = 2'd1,
    REG_PULL_DISTANCE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic [INDEX_BITS-1:0]        column_index;
    logic [INDEX_BITS-1:0]        row_index;
    logic [PROG_BITS-1:0]         progress;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] moved_x;
    logic signed [COORD_BITS-1:0] moved_y;
    logic signed [COORD_BITS-1:0] moved_z;
    logic [INDEX_BITS-1:0]        out_column;
    logic [INDEX_BITS-1:0]        out_row;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] vz;
    logic [INDEX_BITS-1:0]        col;
    logic [INDEX_BITS-1:0]        row;
    logic                         neg_x;
    logic                         neg_y;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy;
    logic [PROD_BITS-1:0]         p;
  } sq_side_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    logic [RAD_BITS-1:0]  rad;
    sq_side_t             side;
  } sq_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] vz;
    logic [INDEX_BITS-1:0]        col;
    logic [INDEX_BITS-1:0]        row;
    logic                         neg_x;
    logic                         neg_y;
    logic                         dz;
    logic                         sat;
  } dv_side_t;

  typedef struct packed {
    logic [DEN_BITS-1:0]  den;
    logic [DEN_BITS-1:0]  rem_x;
    logic [DEN_BITS-1:0]  rem_y;
    logic [QUOT_BITS-1:0] low_x;
    logic [QUOT_BITS-1:0] low_y;
    dv_side_t             side;
  } dv_state_t;

endpackage

>>> rtl/vptp_sqrt_cell.sv
// One root bit of the pipelined integer square root
`timescale 1ns / 1ps
module vptp_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  vptp_pkg::sq_state_t st_in,
  output logic                valid_out,
  output vptp_pkg::sq_state_t st_out
);

  logic [vptp_pkg::REM_BITS-1:0] trial;
  logic [vptp_pkg::REM_BITS-1:0] acc;
  logic                          take;
  vptp_pkg::sq_state_t           st_next;

  always_comb begin
    acc   = {st_in.rem[vptp_pkg::REM_BITS-3:0], st_in.rad[vptp_pkg::RAD_BITS-1 -: 2]};
    trial = {1'b0, st_in.root[vptp_pkg::ROOT_BITS-2:0], 2'b01};
    take  = (acc >= trial);
    st_next      = st_in;
    st_next.rad  = {st_in.rad[vptp_pkg::RAD_BITS-3:0], 2'b00};
    st_next.rem  = take ? (acc - trial) : acc;
    st_next.root = {st_in.root[vptp_pkg::ROOT_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out <= st_next;
    end
  end

endmodule

>>> rtl/vptp_div_cell.sv
// One quotient bit of the two-lane restoring divider
`timescale 1ns / 1ps
module vptp_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  vptp_pkg::dv_state_t st_in,
  output logic                valid_out,
  output vptp_pkg::dv_state_t st_out
);

  logic [vptp_pkg::DEN_BITS:0] tx;
  logic [vptp_pkg::DEN_BITS:0] ty;
  logic [vptp_pkg::DEN_BITS:0] dx_diff;
  logic [vptp_pkg::DEN_BITS:0] dy_diff;
  logic                        take_x;
  logic                        take_y;
  vptp_pkg::dv_state_t         st_next;

  always_comb begin
    tx      = {st_in.rem_x, st_in.low_x[vptp_pkg::QUOT_BITS-1]};
    ty      = {st_in.rem_y, st_in.low_y[vptp_pkg::QUOT_BITS-1]};
    dx_diff = tx - {1'b0, st_in.den};
    dy_diff = ty - {1'b0, st_in.den};
    take_x  = (tx >= {1'b0, st_in.den});
    take_y  = (ty >= {1'b0, st_in.den});
    st_next       = st_in;
    st_next.rem_x = take_x ? dx_diff[vptp_pkg::DEN_BITS-1:0] : tx[vptp_pkg::DEN_BITS-1:0];
    st_next.rem_y = take_y ? dy_diff[vptp_pkg::DEN_BITS-1:0] : ty[vptp_pkg::DEN_BITS-1:0];
    st_next.low_x = {st_in.low_x[vptp_pkg::QUOT_BITS-2:0], take_x};
    st_next.low_y = {st_in.low_y[vptp_pkg::QUOT_BITS-2:0], take_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out <= st_next;
    end
  end

endmodule

>>> rtl/vertex_pull_toward_point.sv
// Top level: pulls each grid vertex toward the configured attraction point
//
// Input channel in_valid/in_ready/in_item carries one vertex with its grid
// indices and progress; output channel out_valid/out_ready/out_item carries
// the moved vertex. Every input item gives exactly one result, in order.
// Configuration is a write port (cfg_we, cfg_index, cfg_data): index 0 is
// centre x, 1 centre y, 2 pull distance; other indexes are ignored.
// Throughput is one item per cycle while the output does not stall. The
// stages are one for the offsets, one for the squares and pull*progress,
// one for the sum, 25 square root cells (one root bit each), one for the
// denominator and split products, one for the product sum, 24 divider cells
// (one quotient bit each, x and y side by side) and the output register.
// The pipeline advances as one whole; when the output item is not taken the
// whole row holds and in_ready falls until out_ready returns.
// Synchronous reset empties the pipeline and clears the configuration registers to zero.
`timescale 1ns / 1ps
module vertex_pull_toward_point (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  vptp_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output vptp_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [vptp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [vptp_pkg::COORD_BITS-1:0]      cfg_data
);

  localparam int SQ_CELLS = vptp_pkg::ROOT_BITS;
  localparam int DV_CELLS = vptp_pkg::QUOT_BITS;
  localparam int CW       = vptp_pkg::COORD_BITS;

  logic signed [CW-1:0]             center_x;
  logic signed [CW-1:0]             center_y;
  logic [vptp_pkg::PULL_BITS-1:0]   pull_distance;
  logic                             en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      pull_distance <= '0;
    end else if (cfg_we) begin
      case (vptp_pkg::cfg_reg_t'(cfg_index))
        vptp_pkg::REG_CENTER_X:      center_x      <= cfg_data;
        vptp_pkg::REG_CENTER_Y:      center_y      <= cfg_data;
        vptp_pkg::REG_PULL_DISTANCE: pull_distance <= cfg_data[vptp_pkg::PULL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // offsets from the centre
  logic [CW:0]             sx;
  logic [CW:0]             sy;
  logic [CW:0]             mag_x;
  logic [CW:0]             mag_y;
  logic                    a_valid;
  vptp_pkg::sq_side_t      a_side;
  logic [vptp_pkg::PROG_BITS-1:0] a_prog;

  always_comb begin
    sx    = {in_item.vertex_x[CW-1], in_item.vertex_x} - {center_x[CW-1], center_x};
    sy    = {in_item.vertex_y[CW-1], in_item.vertex_y} - {center_y[CW-1], center_y};
    mag_x = sx[CW] ? ((CW+1)'(0) - sx) : sx;
    mag_y = sy[CW] ? ((CW+1)'(0) - sy) : sy;
  end

  // squares and pull * progress
  logic                            b_valid;
  vptp_pkg::sq_side_t              b_side;
  vptp_pkg::sq_side_t              b_side_next;
  logic [2*CW-1:0]                 b_dx2;
  logic [2*CW-1:0]                 b_dy2;
  logic [2*CW-1:0]                 sq_x;
  logic [2*CW-1:0]                 sq_y;
  logic [vptp_pkg::PROD_BITS-1:0]  pt;

  assign sq_x = a_side.dx * a_side.dx;
  assign sq_y = a_side.dy * a_side.dy;
  assign pt   = pull_distance * a_prog;

  always_comb begin
    b_side_next   = a_side;
    b_side_next.p = pt;
  end

  logic                 sq_valid [0:SQ_CELLS];
  vptp_pkg::sq_state_t  sq_st    [0:SQ_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      a_valid     <= in_valid;
      b_valid     <= a_valid;
      sq_valid[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.vx    <= in_item.vertex_x;
      a_side.vy    <= in_item.vertex_y;
      a_side.vz    <= in_item.vertex_z;
      a_side.col   <= in_item.column_index;
      a_side.row   <= in_item.row_index;
      a_side.neg_x <= sx[CW];
      a_side.neg_y <= sy[CW];
      a_side.dx    <= mag_x[CW-1:0];
      a_side.dy    <= mag_y[CW-1:0];
      a_side.p     <= '0;
      a_prog       <= in_item.progress;
      b_side       <= b_side_next;
      b_dx2        <= sq_x;
      b_dy2        <= sq_y;
      sq_st[0].rem  <= '0;
      sq_st[0].root <= '0;
      sq_st[0].rad  <= vptp_pkg::RAD_BITS'({1'b0, b_dx2} + {1'b0, b_dy2});
      sq_st[0].side <= b_side;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < SQ_CELLS; gi++) begin : g_sq
      vptp_sqrt_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .valid_in  (sq_valid[gi]),
        .st_in     (sq_st[gi]),
        .valid_out (sq_valid[gi+1]),
        .st_out    (sq_st[gi+1])
      );
    end
  endgenerate

  // denominator, flags and split products
  vptp_pkg::sq_state_t             sq_end;
  logic [vptp_pkg::DEN_BITS-1:0]   den;
  logic                            e_valid;
  vptp_pkg::dv_side_t              e_side;
  logic [vptp_pkg::DEN_BITS-1:0]   e_den;
  logic [vptp_pkg::NUM_BITS-1:0]   e_lo_x;
  logic [vptp_pkg::NUM_BITS-1:0]   e_hi_x;
  logic [vptp_pkg::NUM_BITS-1:0]   e_lo_y;
  logic [vptp_pkg::NUM_BITS-1:0]   e_hi_y;
  logic [vptp_pkg::NUM_BITS-1:0]   num_x;
  logic [vptp_pkg::NUM_BITS-1:0]   num_y;

  localparam int SB = vptp_pkg::SPLIT_BITS;
  localparam int HB = vptp_pkg::PROD_BITS - SB;

  assign sq_end = sq_st[SQ_CELLS];
  assign den    = {sq_end.root, 16'd0};
  assign num_x  = e_lo_x + {e_hi_x[vptp_pkg::NUM_BITS-SB-1:0], {SB{1'b0}}};
  assign num_y  = e_lo_y + {e_hi_y[vptp_pkg::NUM_BITS-SB-1:0], {SB{1'b0}}};

  logic                 dv_valid [0:DV_CELLS];
  vptp_pkg::dv_state_t  dv_st    [0:DV_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid     <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      e_valid     <= sq_valid[SQ_CELLS];
      dv_valid[0] <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side.vx    <= sq_end.side.vx;
      e_side.vy    <= sq_end.side.vy;
      e_side.vz    <= sq_end.side.vz;
      e_side.col   <= sq_end.side.col;
      e_side.row   <= sq_end.side.row;
      e_side.neg_x <= sq_end.side.neg_x;
      e_side.neg_y <= sq_end.side.neg_y;
      e_side.dz    <= (sq_end.root == '0);
      e_side.sat   <= ({1'b0, sq_end.side.p} >= den);
      e_den        <= den;
      e_lo_x <= vptp_pkg::NUM_BITS'(sq_end.side.dx * sq_end.side.p[SB-1:0]);
      e_hi_x <= vptp_pkg::NUM_BITS'(sq_end.side.dx * sq_end.side.p[vptp_pkg::PROD_BITS-1 -: HB]);
      e_lo_y <= vptp_pkg::NUM_BITS'(sq_end.side.dy * sq_end.side.p[SB-1:0]);
      e_hi_y <= vptp_pkg::NUM_BITS'(sq_end.side.dy * sq_end.side.p[vptp_pkg::PROD_BITS-1 -: HB]);
      dv_st[0].den   <= e_den;
      dv_st[0].rem_x <= vptp_pkg::DEN_BITS'(num_x[vptp_pkg::NUM_BITS-1:vptp_pkg::QUOT_BITS]);
      dv_st[0].rem_y <= vptp_pkg::DEN_BITS'(num_y[vptp_pkg::NUM_BITS-1:vptp_pkg::QUOT_BITS]);
      dv_st[0].low_x <= num_x[vptp_pkg::QUOT_BITS-1:0];
      dv_st[0].low_y <= num_y[vptp_pkg::QUOT_BITS-1:0];
      dv_st[0].side  <= e_side;
    end
  end

  generate
    for (gi = 0; gi < DV_CELLS; gi++) begin : g_dv
      vptp_div_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .valid_in  (dv_valid[gi]),
        .st_in     (dv_st[gi]),
        .valid_out (dv_valid[gi+1]),
        .st_out    (dv_st[gi+1])
      );
    end
  endgenerate

  // step toward the centre, or land on it
  vptp_pkg::dv_state_t dv_end;
  logic [CW-1:0]       mx;
  logic [CW-1:0]       my;

  assign dv_end = dv_st[DV_CELLS];

  always_comb begin
    if (dv_end.side.dz) begin
      mx = dv_end.side.vx;
      my = dv_end.side.vy;
    end else if (dv_end.side.sat) begin
      mx = center_x;
      my = center_y;
    end else begin
      mx = dv_end.side.neg_x ? (dv_end.side.vx + dv_end.low_x) : (dv_end.side.vx - dv_end.low_x);
      my = dv_end.side.neg_y ? (dv_end.side.vy + dv_end.low_y) : (dv_end.side.vy - dv_end.low_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[DV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.moved_x    <= mx;
      out_item.moved_y    <= my;
      out_item.moved_z    <= dv_end.side.vz;
      out_item.out_column <= dv_end.side.col;
      out_item.out_row    <= dv_end.side.row;
    end
  end

  a_sqrt_exact: assert property (@(posedge clk) disable iff (rst)
    sq_valid[SQ_CELLS] |-> ({2'b00, sq_end.rem} <= {1'b0, sq_end.root, 1'b0} + 27'd0))
    else $error("square root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_valid[DV_CELLS] && !dv_end.side.dz && !dv_end.side.sat) |->
      (dv_end.rem_x < dv_end.den && dv_end.rem_y < dv_end.den))
    else $error("divider remainder not below denominator");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
